>>> design/ndpr_pkg.sv
package ndpr_pkg;

   localparam int RING_DEPTH_DEF    = 8;
   localparam int PAYLOAD_BYTES_DEF = 8;
   localparam int WAITER_DEPTH_DEF  = 16;

   typedef logic [2:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KIND_SIGNAL     = 3'd0;
   localparam kind_type KIND_SIGNAL_PAY = 3'd1;
   localparam kind_type KIND_WAIT       = 3'd2;
   localparam kind_type KIND_POLL       = 3'd3;
   localparam kind_type KIND_POP        = 3'd4;

   localparam status_type STATUS_DONE       = 2'd0;
   localparam status_type STATUS_QUEUED     = 2'd1;
   localparam status_type STATUS_QUEUE_FULL = 2'd2;
   localparam status_type STATUS_RING_EMPTY = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

>>> design/ndpr_ram.sv
module ndpr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/notification_doorbell_payload_ring.sv
// Channel  | Handshake            | Carries
// ---------+----------------------+-----------------------------------------------
// req      | req_valid/req_ready  | kind, signal_bits, task_id, payload_data/len
// rsp      | rsp_valid/rsp_ready  | status, woke_waiter, woken_task, bits_out,
//          |                      | payload_out, payload_count_out
//
// Each transfer is accepted in ST_IDLE, whose accept cycle reads the heads of the
// waiter RAM and the payload ring RAM; ST_EXEC uses the registered read data,
// writes back and loads the result register. One item is in flight at a time.
// Synchronous active-high reset empties both queues and clears pending bits;
// the RAMs need no clearing. The result register holds until taken; a new item
// may be accepted while it waits, but completes only once the register is free.
module notification_doorbell_payload_ring #(
   parameter int RING_DEPTH    = ndpr_pkg::RING_DEPTH_DEF,
   parameter int PAYLOAD_BYTES = ndpr_pkg::PAYLOAD_BYTES_DEF,
   parameter int WAITER_DEPTH  = ndpr_pkg::WAITER_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ndpr_pkg::kind_type   req_kind,
   input  logic [63:0]          req_signal_bits,
   input  logic [15:0]          req_task_id,
   input  logic [63:0]          req_payload_data,
   input  logic [7:0]           req_payload_len,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ndpr_pkg::status_type rsp_status,
   output logic                 rsp_woke_waiter,
   output logic [15:0]          rsp_woken_task,
   output logic [63:0]          rsp_bits_out,
   output logic [63:0]          rsp_payload_out,
   output logic [3:0]           rsp_payload_count_out
);
   import ndpr_pkg::*;

   localparam int RAW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int RCW = $clog2(RING_DEPTH + 1);
   localparam int WAW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int WCW = $clog2(WAITER_DEPTH + 1);

   state_type state_ff, state_in;

   logic [63:0]    pending_ff, pending_in;
   logic [WAW-1:0] whead_ff, whead_in, wtail_ff, wtail_in;
   logic [WCW-1:0] wcount_ff, wcount_in;
   logic [RAW-1:0] rhead_ff, rhead_in, rtail_ff, rtail_in;
   logic [RCW-1:0] rcount_ff, rcount_in;

   kind_type    kind_ff;
   logic [63:0] sbits_ff;
   logic [15:0] tid_ff;
   logic [63:0] data_ff;
   logic [7:0]  len_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic        woke_ff, woke_in;
   logic [15:0] wtask_ff, wtask_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] pdata_ff, pdata_in;
   logic [3:0]  pcount_ff, pcount_in;

   logic          accept, finish;
   logic          w_wr_en, r_wr_en;
   logic [15:0]   w_rd_data;
   logic [127:0]  r_rd_data;
   logic [63:0]   masked_data;
   logic [63:0]   merged;
   logic [RCW+3:0] rcount_ext;

   ndpr_ram #(.WIDTH(16), .DEPTH(WAITER_DEPTH)) u_waiter_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (wtail_ff),
      .wr_data (tid_ff),
      .rd_addr (whead_ff),
      .rd_data (w_rd_data)
   );

   ndpr_ram #(.WIDTH(128), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (rtail_ff),
      .wr_data ({sbits_ff, masked_data}),
      .rd_addr (rhead_ff),
      .rd_data (r_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: finish    = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked_data[i*8 +: 8] = ((32'(len_ff) > i) && (i < PAYLOAD_BYTES)) ?
                                 data_ff[i*8 +: 8] : 8'd0;
      end
   end

   assign merged = pending_ff | sbits_ff;

   always_comb begin
      pending_in = pending_ff;
      whead_in   = whead_ff;
      wtail_in   = wtail_ff;
      wcount_in  = wcount_ff;
      rhead_in   = rhead_ff;
      rtail_in   = rtail_ff;
      rcount_in  = rcount_ff;
      w_wr_en    = 1'b0;
      r_wr_en    = 1'b0;
      status_in  = STATUS_DONE;
      woke_in    = 1'b0;
      wtask_in   = 16'd0;
      bits_in    = 64'd0;
      pdata_in   = 64'd0;

      if (finish) begin
         unique case (kind_ff)
            KIND_SIGNAL, KIND_SIGNAL_PAY: begin
               pending_in = merged;
               if (kind_ff == KIND_SIGNAL_PAY) begin
                  r_wr_en  = 1'b1;
                  rtail_in = (rtail_ff == RAW'(RING_DEPTH - 1)) ? '0 : rtail_ff + 1'b1;
                  if (rcount_ff == RCW'(RING_DEPTH)) begin
                     rhead_in = (rhead_ff == RAW'(RING_DEPTH - 1)) ? '0 : rhead_ff + 1'b1;
                  end else begin
                     rcount_in = rcount_ff + 1'b1;
                  end
               end
               if (wcount_ff != '0) begin
                  woke_in    = 1'b1;
                  wtask_in   = w_rd_data;
                  bits_in    = merged;
                  pending_in = 64'd0;
                  whead_in   = (whead_ff == WAW'(WAITER_DEPTH - 1)) ? '0 : whead_ff + 1'b1;
                  wcount_in  = wcount_ff - 1'b1;
               end
            end
            KIND_WAIT: begin
               if (pending_ff != 64'd0) begin
                  bits_in    = pending_ff;
                  pending_in = 64'd0;
               end else if (wcount_ff < WCW'(WAITER_DEPTH)) begin
                  w_wr_en   = 1'b1;
                  wtail_in  = (wtail_ff == WAW'(WAITER_DEPTH - 1)) ? '0 : wtail_ff + 1'b1;
                  wcount_in = wcount_ff + 1'b1;
                  status_in = STATUS_QUEUED;
               end else begin
                  status_in = STATUS_QUEUE_FULL;
               end
            end
            KIND_POLL: begin
               bits_in    = pending_ff;
               pending_in = 64'd0;
            end
            KIND_POP: begin
               if (rcount_ff == '0) begin
                  status_in = STATUS_RING_EMPTY;
               end else begin
                  bits_in   = r_rd_data[127:64];
                  pdata_in  = r_rd_data[63:0];
                  rhead_in  = (rhead_ff == RAW'(RING_DEPTH - 1)) ? '0 : rhead_ff + 1'b1;
                  rcount_in = rcount_ff - 1'b1;
               end
            end
            default: status_in = STATUS_DONE;
         endcase
      end
   end

   assign rcount_ext = {4'd0, rcount_in};
   assign pcount_in  = rcount_ext[3:0];

   assign rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 64'd0;
         whead_ff     <= '0;
         wtail_ff     <= '0;
         wcount_ff    <= '0;
         rhead_ff     <= '0;
         rtail_ff     <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         whead_ff     <= whead_in;
         wtail_ff     <= wtail_in;
         wcount_ff    <= wcount_in;
         rhead_ff     <= rhead_in;
         rtail_ff     <= rtail_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         sbits_ff <= req_signal_bits;
         tid_ff   <= req_task_id;
         data_ff  <= req_payload_data;
         len_ff   <= req_payload_len;
      end
      if (finish) begin
         status_ff <= status_in;
         woke_ff   <= woke_in;
         wtask_ff  <= wtask_in;
         bits_ff   <= bits_in;
         pdata_ff  <= pdata_in;
         pcount_ff <= pcount_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_woke_waiter       = woke_ff;
   assign rsp_woken_task        = wtask_ff;
   assign rsp_bits_out          = bits_ff;
   assign rsp_payload_out       = pdata_ff;
   assign rsp_payload_count_out = pcount_ff;

`ifndef SYNTHESIS
   a_wcount_bound: assert property (@(posedge clock) disable iff (reset)
      wcount_ff <= WCW'(WAITER_DEPTH))
      else $error("waiter count above depth");

   a_rcount_bound: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= RCW'(RING_DEPTH))
      else $error("ring count above depth");

   a_woke_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && woke_ff) |-> (status_ff == STATUS_DONE))
      else $error("wake reported with wrong status");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> (!req_ready && !w_wr_en && !r_wr_en) || finish)
      else $error("accept overlaps item in flight");
`endif

endmodule
